// ===== sv/idpa_pkg.sv =====
// ----------------------------------------------------------------------------
// idpa_pkg
// Shared types and constants for the ID pool allocator: command and status
// codes, the decoded request that goes from the front end to the back end,
// and the back-end state encoding.
// ----------------------------------------------------------------------------
package idpa_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 256;
    localparam int ID_W      = 8;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_SIZE);
    localparam logic [ID_W-1:0]  LAST_ID  = ID_W'(POOL_SIZE - 1);

    // Command codes on the input port
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    // Status codes on the output port
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY_SLOT = 2'd2;

    // Decoded operation
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_DELETE,
        OP_NONE
    } op_t;

    // Request handed from front end to back end
    typedef struct packed {
        op_t              op;
        logic [DATA_W-1:0] data;
        logic [ID_W-1:0]   idx;
    } req_t;

    // Back-end sequencer
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

    // Ring position advance with wrap at the pool size
    function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] pos);
        ring_next = (pos == LAST_ID) ? '0 : pos + 1'b1;
    endfunction

endpackage

// ===== sv/idpa_front.sv =====
// ----------------------------------------------------------------------------
// idpa_front
// Input side: accepts transactions, decodes the command into an operation
// and buffers decoded requests in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module idpa_front
    import idpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [DATA_W-1:0] entry_data,
    input  logic [ID_W-1:0]   slot_index,
    output logic              q_valid,
    output req_t              q_req,
    input  logic              q_pop
);

    req_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    req_t              dec_req;
    logic              push;

    // Command decode
    always_comb
    begin
        dec_req.data = entry_data;
        dec_req.idx  = slot_index;
        unique case (command)
            CMD_INSERT: dec_req.op = OP_INSERT;
            CMD_QUERY:  dec_req.op = OP_QUERY;
            CMD_DELETE: dec_req.op = OP_DELETE;
            default:    dec_req.op = OP_NONE;
        endcase
    end

    // Queue control
    assign in_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_req    = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= dec_req;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// ===== sv/idpa_back.sv =====
// ----------------------------------------------------------------------------
// idpa_back
// Execution side: holds the free-ID ring, the entry store and the slot
// valid bits. Each request goes through a read step and an execute step; the
// result goes to an output register that parts it from the consumer.
// ----------------------------------------------------------------------------
module idpa_back
    import idpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  req_t              q_req,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   slot_id,
    output logic              present,
    output logic [DATA_W-1:0] entry_out,
    output logic              pool_full,
    output logic [CNT_W-1:0]  occupied_count
);

    // Memories
    logic [ID_W-1:0]   ring_mem  [POOL_SIZE];
    logic [DATA_W-1:0] entry_mem [POOL_SIZE];
    logic [ID_W-1:0]   ring_q;
    logic [DATA_W-1:0] entry_q;

    // Control and bookkeeping
    bk_state_t         state_reg, state_next;
    req_t              cur_reg;
    logic [POOL_SIZE-1:0] slot_valid_reg, slot_valid_next;
    logic [ID_W-1:0]   head_reg, head_next;
    logic [ID_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  push_cnt_reg, push_cnt_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [ID_W-1:0]   slot_id_reg, slot_id_next;
    logic              present_reg, present_next;
    logic [DATA_W-1:0] entry_out_reg, entry_out_next;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  occ_out_reg;

    logic              exec;
    logic              entry_we;
    logic              ring_we;
    logic [ID_W-1:0]   alloc_id;
    logic              hit;

    // Sequencer: issue reads in idle, then execute in BK_EXEC
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        exec       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_pop      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                exec       = 1'b1;
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Ring positions never pushed since reset still hold their own ID
    assign alloc_id = ({1'b0, head_reg} < push_cnt_reg) ? ring_q : head_reg;
    assign hit      = slot_valid_reg[cur_reg.idx];

    // Execute
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        push_cnt_next   = push_cnt_reg;
        status_next     = ST_OK;
        slot_id_next    = '0;
        present_next    = 1'b0;
        entry_out_next  = '0;
        entry_we        = 1'b0;
        ring_we         = 1'b0;
        if (exec)
        begin
            unique case (cur_reg.op)
                OP_INSERT:
                begin
                    if (occ_reg == POOL_CNT)
                        status_next = ST_FULL;
                    else
                    begin
                        slot_id_next              = alloc_id;
                        slot_valid_next[alloc_id] = 1'b1;
                        entry_we                  = 1'b1;
                        head_next                 = ring_next(head_reg);
                        occ_next                  = occ_reg + 1'b1;
                    end
                end
                OP_QUERY:
                    present_next = hit;
                OP_DELETE:
                begin
                    if (hit)
                    begin
                        present_next                 = 1'b1;
                        entry_out_next               = entry_q;
                        slot_valid_next[cur_reg.idx] = 1'b0;
                        ring_we                      = 1'b1;
                        tail_next                    = ring_next(tail_reg);
                        occ_next                     = occ_reg - 1'b1;
                        if (push_cnt_reg != POOL_CNT)
                            push_cnt_next = push_cnt_reg + 1'b1;
                    end
                    else
                        status_next = ST_EMPTY_SLOT;
                end
                default: ;
            endcase
        end
        full_next = (occ_next == POOL_CNT);
    end

    // Output handshake
    always_comb
    begin
        if (exec)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            slot_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            push_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            occ_reg        <= occ_next;
            push_cnt_reg   <= push_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_req;
        if (exec)
        begin
            status_reg    <= status_next;
            slot_id_reg   <= slot_id_next;
            present_reg   <= present_next;
            entry_out_reg <= entry_out_next;
            full_reg      <= full_next;
            occ_out_reg   <= occ_next;
        end
    end

    // Memory reads (registered) and writes
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ring_q  <= ring_mem[head_reg];
            entry_q <= entry_mem[q_req.idx];
        end
        if (ring_we)
            ring_mem[tail_reg] <= cur_reg.idx;
        if (entry_we)
            entry_mem[alloc_id] <= cur_reg.data;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign slot_id        = slot_id_reg;
    assign present        = present_reg;
    assign entry_out      = entry_out_reg;
    assign pool_full      = full_reg;
    assign occupied_count = occ_out_reg;

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= POOL_CNT)
        else $error("occupied count beyond pool size");

    a_ring_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg - tail_reg) == occ_reg[ID_W-1:0])
        else $error("ring pointers disagree with occupied count");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == 32'(occ_reg))
        else $error("slot valid bits disagree with occupied count");

    a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed request produced no result");

endmodule

// ===== sv/id_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// id_pool_allocator_unit
// ID pool allocator: hands out slot IDs from a FIFO of free IDs and keeps
// one entry word per slot, with insert, query and delete commands.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is queued in the front end, popped with the
//   memory read, then executed into the output register.
// The back end takes no new request until the last has executed (read, then
//   execute on the single-port ring and entry memories) or while its output is held.
// Reset: all slots empty, free ring holds IDs zero upward; usable at once.
module id_pool_allocator_unit
    import idpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [DATA_W-1:0] entry_data,
    input  logic [ID_W-1:0]   slot_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   slot_id,
    output logic              present,
    output logic [DATA_W-1:0] entry_out,
    output logic              pool_full,
    output logic [CNT_W-1:0]  occupied_count
);

    logic q_valid;
    logic q_pop;
    req_t q_req;

    // Front end: decode and buffer
    idpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .entry_data (entry_data),
        .slot_index (slot_index),
        .q_valid    (q_valid),
        .q_req      (q_req),
        .q_pop      (q_pop)
    );

    // Back end: execute against pool state
    idpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_req          (q_req),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_id        (slot_id),
        .present        (present),
        .entry_out      (entry_out),
        .pool_full      (pool_full),
        .occupied_count (occupied_count)
    );

endmodule

// ===== dv/id_pool_allocator_unit_test.sv =====
// ----------------------------------------------------------------------------
// id_pool_allocator_unit_test
// Self-checking bench for the ID pool allocator. A directed prologue covers
// the corner commands, then a random run fills the pool to full, hovers there,
// drains it to four live slots and ends in a balanced mix. A behavioral copy of
// the pool predicts every result; the result port is checked field by field.
// ----------------------------------------------------------------------------
module id_pool_allocator_unit_test
    import idpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 2000;
    localparam int         TAIL_WAIT  = 10;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] data;
        logic [ID_W-1:0]   idx;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   slot_id;
        logic              present;
        logic [DATA_W-1:0] entry_out;
        logic              pool_full;
        logic [CNT_W-1:0]  occupied_count;
    } alloc_result_t;

    // DUT ports
    logic              clk;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic [1:0]        command        = CMD_INSERT;
    logic [DATA_W-1:0] entry_data     = '0;
    logic [ID_W-1:0]   slot_index     = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [1:0]        status;
    logic [ID_W-1:0]   slot_id;
    logic              present;
    logic [DATA_W-1:0] entry_out;
    logic              pool_full;
    logic [CNT_W-1:0]  occupied_count;

    // Bench state
    alloc_req_t    request_q[$];
    alloc_result_t outcome_q[$];
    alloc_req_t    next_req;
    int            fail_count   = 0;
    int            results_seen = 0;
    int            send_gap     = 0;
    int            send_calm    = 0;
    int            recv_stall   = 0;
    int            recv_calm    = 0;
    int            hold_left    = 0;
    int            idle_cycles  = 0;

    // Behavioral pool used for prediction
    logic [ID_W-1:0]   free_ids   [POOL_SIZE];
    logic [DATA_W-1:0] slot_words [POOL_SIZE];
    logic              slot_busy  [POOL_SIZE];
    int                free_head;
    int                free_tail;
    int                busy_count;

    // Stimulus-side view of which slots are live, used to aim deletes and queries
    logic [ID_W-1:0] gen_free[$];
    logic [ID_W-1:0] gen_live[$];
    logic            gen_busy [POOL_SIZE];

    id_pool_allocator_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .entry_data     (entry_data),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .slot_id        (slot_id),
        .present        (present),
        .entry_out      (entry_out),
        .pool_full      (pool_full),
        .occupied_count (occupied_count)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Apply one request to the behavioral pool and return the result it gives
    function automatic alloc_result_t pool_step(input alloc_req_t r);
        alloc_result_t res;
        logic [ID_W-1:0] id;
        res = '0;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (busy_count >= POOL_SIZE)
                    res.status = ST_FULL;
                else
                begin
                    id = free_ids[free_head];
                    free_head = (free_head + 1) % POOL_SIZE;
                    slot_words[id] = r.data;
                    slot_busy[id] = 1'b1;
                    busy_count++;
                    res.slot_id = id;
                end
            end
            CMD_QUERY:
                res.present = slot_busy[r.idx];
            CMD_DELETE:
            begin
                if (slot_busy[r.idx])
                begin
                    res.present = 1'b1;
                    res.entry_out = slot_words[r.idx];
                    slot_busy[r.idx] = 1'b0;
                    slot_words[r.idx] = '0;
                    free_ids[free_tail] = r.idx;
                    free_tail = (free_tail + 1) % POOL_SIZE;
                    busy_count--;
                end
                else
                    res.status = ST_EMPTY_SLOT;
            end
            default: ;
        endcase
        res.pool_full = (busy_count >= POOL_SIZE);
        res.occupied_count = CNT_W'(busy_count);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long; calm stretches give zero
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return DATA_W'($urandom);
    endfunction

    // Queue a request and track which slots it leaves live
    task automatic queue_request(input logic [1:0] cmd, input logic [DATA_W-1:0] data,
                                 input logic [ID_W-1:0] idx);
        alloc_req_t r;
        r.cmd = cmd;
        r.data = data;
        r.idx = idx;
        request_q.push_back(r);
        if (cmd == CMD_INSERT && gen_free.size() > 0)
        begin
            gen_busy[gen_free[0]] = 1'b1;
            gen_live.push_back(gen_free.pop_front());
        end
        else if (cmd == CMD_DELETE && gen_busy[idx])
        begin
            gen_busy[idx] = 1'b0;
            gen_free.push_back(idx);
            foreach (gen_live[i])
            begin
                if (gen_live[i] == idx)
                begin
                    gen_live.delete(i);
                    break;
                end
            end
        end
    endtask

    // One random request; deletes and queries mostly aim at live slots
    task automatic queue_random(input int ins_pct, input int del_pct);
        int r;
        logic [ID_W-1:0] idx;
        r = $urandom_range(0, 99);
        if (gen_live.size() > 0 && $urandom_range(0, 99) < 80)
            idx = gen_live[$urandom_range(0, gen_live.size() - 1)];
        else
            idx = ID_W'($urandom);
        if (r < ins_pct)
            queue_request(CMD_INSERT, rand_word(), ID_W'($urandom));
        else if (r < ins_pct + del_pct)
            queue_request(CMD_DELETE, rand_word(), idx);
        else
            queue_request(CMD_QUERY, rand_word(), idx);
    endtask

    task automatic compare_outcome(input alloc_result_t exp_r, input alloc_result_t got);
        if (got.status !== exp_r.status)
        begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            fail_count++;
        end
        if (got.slot_id !== exp_r.slot_id)
        begin
            $error("slot_id: expected %0d, got %0d", exp_r.slot_id, got.slot_id);
            fail_count++;
        end
        if (got.present !== exp_r.present)
        begin
            $error("present: expected %0d, got %0d", exp_r.present, got.present);
            fail_count++;
        end
        if (got.entry_out !== exp_r.entry_out)
        begin
            $error("entry_out: expected %08h, got %08h", exp_r.entry_out, got.entry_out);
            fail_count++;
        end
        if (got.pool_full !== exp_r.pool_full)
        begin
            $error("pool_full: expected %0d, got %0d", exp_r.pool_full, got.pool_full);
            fail_count++;
        end
        if (got.occupied_count !== exp_r.occupied_count)
        begin
            $error("occupied_count: expected %0d, got %0d",
                   exp_r.occupied_count, got.occupied_count);
            fail_count++;
        end
    endtask

    // Driver: predict on each accepted transaction, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            command    <= CMD_INSERT;
            entry_data <= '0;
            slot_index <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                outcome_q.push_back(pool_step({command, entry_data, slot_index}));
                send_gap = next_gap(send_calm);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    next_req = request_q.pop_front();
                    in_valid   <= 1'b1;
                    command    <= next_req.cmd;
                    entry_data <= next_req.data;
                    slot_index <= next_req.idx;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result, and drive random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                    compare_outcome(outcome_q.pop_front(),
                                    {status, slot_id, present, entry_out,
                                     pool_full, occupied_count});
                results_seen++;
                // one long hold-off so the block backs up into its input
                if (results_seen == 200)
                    hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (recv_stall == 0 && $urandom_range(0, 3) == 0)
                    recv_stall = next_gap(recv_calm);
                if (recv_stall > 0)
                begin
                    recv_stall--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("id_pool_allocator_unit verification failed");
            $finish;
        end
    end

    // Stimulus and end of test
    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            free_ids[i] = ID_W'(i);
            slot_words[i] = '0;
            slot_busy[i] = 1'b0;
            gen_busy[i] = 1'b0;
            gen_free.push_back(ID_W'(i));
        end
        free_head = 0;
        free_tail = 0;
        busy_count = 0;

        // directed: data extremes, every command, empty-slot delete, unused code
        queue_request(CMD_INSERT, '0, '0);
        queue_request(CMD_INSERT, '1, '1);
        queue_request(CMD_INSERT, 32'hA5A5_5A5A, 8'h5A);
        queue_request(CMD_QUERY, '1, 8'd0);
        queue_request(CMD_QUERY, '0, 8'd255);
        queue_request(CMD_QUERY, '0, 8'd1);
        queue_request(CMD_DELETE, '1, 8'd0);
        queue_request(CMD_DELETE, '0, 8'd0);
        queue_request(CMD_DELETE, '0, 8'd255);
        queue_request(CMD_DELETE, '0, 8'd1);
        queue_request(CMD_UNUSED, '1, '1);
        queue_request(CMD_INSERT, 32'h5A5A_A5A5, 8'hA5);
        queue_request(CMD_QUERY, '0, 8'd0);
        queue_request(CMD_QUERY, '0, 8'd3);
        queue_request(CMD_DELETE, '0, 8'd2);
        queue_request(CMD_INSERT, 32'h8000_0001, '0);

        // random: fill to full, sit at full, drain, then a balanced mix
        while (gen_live.size() < POOL_SIZE)
            queue_random(75, 15);
        repeat (16)
            queue_random(60, 10);
        while (gen_live.size() > 4)
            queue_random(15, 75);
        repeat (100)
            queue_random(40, 40);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("id_pool_allocator_unit verification clean");
        else
            $display("id_pool_allocator_unit verification failed");
        $finish;
    end

endmodule
